/* rtl/core/u16u8_pkg.sv */
// shared types, constants and byte-forming functions for the utf-16 to utf-8 encoder
// no dependencies; used by the front end, record queue, byte sequencer and top level
`default_nettype none

package u16u8_pkg;

    localparam int CP_W = 21;

    // upper six bits of a surrogate code unit
    localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
    localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [CP_W-1:0] CP_TWO_BYTE    = 21'h000080;
    localparam logic [CP_W-1:0] CP_THREE_BYTE  = 21'h000800;
    localparam logic [CP_W-1:0] CP_FOUR_BYTE   = 21'h010000;

    localparam logic [2:0] LEAD_TWO   = 3'b110;
    localparam logic [3:0] LEAD_THREE = 4'b1110;
    localparam logic [4:0] LEAD_FOUR  = 5'b11110;
    localparam logic [1:0] CONT_MARK  = 2'b10;

    // one queue entry: an optional replacement char followed by an optional code point
    typedef struct packed {
        logic            pre_rep;
        logic            main_valid;
        logic [CP_W-1:0] cp;
    } t_rec;

    // index of the final byte of the encoding (0 to 3)
    function automatic logic [1:0] utf8_last_pos(input logic [CP_W-1:0] cp);
        logic [1:0] last_pos;
        if (cp < CP_TWO_BYTE) begin
            last_pos = 2'd0;
        end else if (cp < CP_THREE_BYTE) begin
            last_pos = 2'd1;
        end else if (cp < CP_FOUR_BYTE) begin
            last_pos = 2'd2;
        end else begin
            last_pos = 2'd3;
        end
        return last_pos;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0]      last_pos,
                                             input logic [1:0]      pos);
        logic [7:0] b;
        logic [1:0] gap;
        gap = last_pos - pos;
        if (pos == 2'd0) begin
            case (last_pos)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {LEAD_TWO, cp[10:6]};
                2'd2:    b = {LEAD_THREE, cp[15:12]};
                default: b = {LEAD_FOUR, cp[20:18]};
            endcase
        end else begin
            case (gap)
                2'd0:    b = {CONT_MARK, cp[5:0]};
                2'd1:    b = {CONT_MARK, cp[11:6]};
                default: b = {CONT_MARK, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/u16u8_if.sv */
// channel interfaces of the encoder: utf-16 unit input and utf-8 byte output
// valid/ready handshake; no dependencies
`default_nettype none

interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_text;

    modport source (output valid, output code_unit, output end_of_text, input ready);
    modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/u16u8_front.sv */
// front end: accepts code units, pairs surrogates, pushes at most one record per word
// depends on u16u8_pkg and u16u8_in_if
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    u16u8_in_if.sink   i_in,
    input  wire        i_q_full,
    output logic       o_push,
    output t_rec       o_rec
);

    logic       r_held_valid;
    logic [9:0] r_held_high;
    logic       n_held_valid;
    logic [9:0] n_held_high;

    logic is_high;
    logic is_low;
    logic accept;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign is_high    = i_in.code_unit[15:10] == HIGH_SURR_PREFIX;
    assign is_low     = i_in.code_unit[15:10] == LOW_SURR_PREFIX;

    always_comb begin
        o_rec.pre_rep    = 1'b0;
        o_rec.main_valid = 1'b1;
        o_rec.cp         = {5'd0, i_in.code_unit};
        n_held_valid     = r_held_valid;
        n_held_high      = r_held_high;
        if (r_held_valid && is_low) begin
            o_rec.cp = CP_SUPP_BASE + {1'b0, r_held_high, i_in.code_unit[9:0]};
        end else begin
            o_rec.pre_rep = r_held_valid;
            if (is_high && !i_in.end_of_text) begin
                o_rec.main_valid = 1'b0;
            end else if (is_high || is_low) begin
                o_rec.cp = CP_REPLACEMENT;
            end
        end
        if (accept) begin
            if (!r_held_valid && is_high && !i_in.end_of_text) begin
                n_held_valid = 1'b1;
                n_held_high  = i_in.code_unit[9:0];
            end else if (r_held_valid && !is_low && is_high && !i_in.end_of_text) begin
                n_held_valid = 1'b1;
                n_held_high  = i_in.code_unit[9:0];
            end else begin
                n_held_valid = 1'b0;
                n_held_high  = 10'd0;
            end
        end
    end

    // a high surrogate that is held adds no code point; a record goes out only if it carries a replacement
    assign o_push = accept && (o_rec.pre_rep || o_rec.main_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_high  <= 10'd0;
        end else begin
            r_held_valid <= n_held_valid;
            r_held_high  <= n_held_high;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u16u8_fifo.sv */
// two-entry record queue between the front end and the byte sequencer
// depends on u16u8_pkg
`default_nettype none

module u16u8_fifo
    import u16u8_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_rec i_rec,
    input  wire  i_pop,
    output t_rec o_rec,
    output logic o_full,
    output logic o_empty
);

    t_rec       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/u16u8_back.sv */
// byte sequencer: expands queued records into utf-8 bytes behind an output register
// depends on u16u8_pkg and u16u8_out_if
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_rec       i_rec,
    input  wire        i_q_empty,
    output logic       o_pop,
    u16u8_out_if.source o_out
);

    logic            r_busy;
    logic            r_rep;
    logic            r_main;
    logic [CP_W-1:0] r_cp;
    logic [1:0]      r_pos;

    logic            r_out_valid;
    logic [7:0]      r_out_byte;
    logic            r_out_last;

    logic [CP_W-1:0] cur_cp;
    logic [1:0]      last_pos;
    logic [7:0]      cur_byte;
    logic            last_of_cp;
    logic            last_of_rec;
    logic            can_load;
    logic            step;

    assign cur_cp      = r_rep ? CP_REPLACEMENT : r_cp;
    assign last_pos    = utf8_last_pos(cur_cp);
    assign cur_byte    = utf8_byte(cur_cp, last_pos, r_pos);
    assign last_of_cp  = r_pos == last_pos;
    // the replacement char is final only when no code point follows it
    assign last_of_rec = last_of_cp && (!r_rep || !r_main);
    assign can_load    = !r_out_valid || o_out.ready;
    assign step        = r_busy && can_load;
    assign o_pop       = !i_q_empty && (!r_busy || (step && last_of_rec));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rep  <= 1'b0;
            r_main <= 1'b0;
            r_pos  <= 2'd0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_rep  <= i_rec.pre_rep;
                r_main <= i_rec.main_valid;
                r_pos  <= 2'd0;
            end else if (step) begin
                if (last_of_rec) begin
                    r_busy <= 1'b0;
                    r_pos  <= 2'd0;
                end else if (last_of_cp) begin
                    r_rep <= 1'b0;
                    r_pos <= 2'd0;
                end else begin
                    r_pos <= r_pos + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cp <= i_rec.cp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte <= cur_byte;
            r_out_last <= last_of_rec;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.run_last = r_out_last;

endmodule

`default_nettype wire

/* rtl/core/utf16_to_utf8_encoder.sv */
// utf-16 to utf-8 encoder, top level
// depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_fifo, u16u8_back
//
// usage:
//   i_in carries one utf-16 code unit per word plus an end-of-text flag.
//   o_out carries one utf-8 byte per word; run_last marks the final byte
//   that an input word causes. a high surrogate that is not the last unit
//   gives no bytes at once: it is held and paired with the next unit.
//   unpaired surrogates come out as U+FFFD (EF BF BD).
// path: an accepted unit is written into the record queue, then loaded into the
//   byte sequencer, and its first byte reaches o_out through the output register.
// throughput: one byte per cycle while o_out.ready is high; a unit yields
//   1 to 3 bytes if plain, 4 for a surrogate pair, and up to 6 when a
//   dropped high surrogate precedes a new unit. the byte
//   sequencer is the limit; a two-entry record queue lets the front end
//   take new units while it works.
// reset: synchronous, active low; clears the held surrogate, the queue and
//   the output register.
// stall: when o_out.ready is low the current byte holds; the queue fills
//   and i_in.ready drops once both entries are taken.
`default_nettype none

module utf16_to_utf8_encoder
    import u16u8_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_out_if.source o_out
);

    t_rec front_rec;
    t_rec head_rec;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    u16u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_rec    (front_rec)
    );

    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_rec   (head_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u16u8_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rec     (head_rec),
        .i_q_empty (q_empty),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

/* rtl/core/u16u8_chk.sv */
// port-level checks for the encoder, attached by bind
// depends on utf16_to_utf8_encoder ports only
`default_nettype none

module u16u8_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_byte,
    input wire       i_out_run_last
);

    // a stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_run_last))
        else $error("output word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // ascii only ever ends a code point that closes the run
    a_ascii_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_byte[7] |-> i_out_run_last)
        else $error("ascii byte not marked last");

    // a multi-byte lead never ends a run, and no invalid lead appears
    a_lead_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_byte[7:6] == 2'b11 |->
            !i_out_run_last && i_out_byte[7:3] != 5'b11111)
        else $error("bad lead byte");

endmodule

bind utf16_to_utf8_encoder u16u8_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_run_last (o_out.run_last)
);

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// testbench for utf16_to_utf8_encoder: random and directed utf-16 units, bytes checked in order
// depends on u16u8_pkg, u16u8_if and the encoder rtl; a scoreboard class predicts the byte stream

module tb;
    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_exp_byte;

    typedef enum {
        K_ASCII,
        K_TWO,
        K_THREE,
        K_PAIR,
        K_LONE_HIGH,
        K_LONE_LOW,
        K_ANY
    } t_unit_kind;

    // predicts the utf-8 byte stream and checks the bytes that come out
    class t_utf8_tracker;
        logic [9:0] held_high;
        logic       held_valid;
        t_exp_byte  expected_bytes[$];
        int         errors;
        int         units;
        int         bytes_checked;
        int         pairs;
        int         replacements;

        function new();
            held_high     = '0;
            held_valid    = 1'b0;
            errors        = 0;
            units         = 0;
            bytes_checked = 0;
            pairs         = 0;
            replacements  = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] b);
            t_exp_byte e;
            e.value = b;
            e.last  = 1'b0;
            expected_bytes.insert(expected_bytes.size(), e);
        endfunction

        function void push_cp(logic [CP_W-1:0] cp);
            if (cp < 21'h80) begin
                push_byte(cp[7:0]);
            end else if (cp < 21'h800) begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end else if (cp < 21'h10000) begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end else begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
        endfunction

        function void push_replacement();
            push_cp(CP_REPLACEMENT);
            replacements++;
        endfunction

        function void note_unit(logic [15:0] unit, logic eot);
            logic is_high;
            logic is_low;
            int   start_n;
            start_n = expected_bytes.size();
            is_high = (unit[15:10] == HIGH_SURR_PREFIX);
            is_low  = (unit[15:10] == LOW_SURR_PREFIX);
            units++;
            if (held_valid && is_low) begin
                push_cp(21'h10000 + {1'b0, held_high, unit[9:0]});
                pairs++;
                held_valid = 1'b0;
                held_high  = '0;
            end else begin
                // a held high surrogate with no low partner is dropped as U+FFFD
                if (held_valid) begin
                    push_replacement();
                    held_valid = 1'b0;
                    held_high  = '0;
                end
                if (is_high) begin
                    if (eot) begin
                        push_replacement();
                    end else begin
                        held_high  = unit[9:0];
                        held_valid = 1'b1;
                    end
                end else if (is_low) begin
                    push_replacement();
                end else begin
                    push_cp({5'd0, unit});
                end
            end
            if (expected_bytes.size() > start_n) begin
                expected_bytes[expected_bytes.size()-1].last = 1'b1;
            end
        endfunction

        function void check_byte(logic [7:0] b, logic last);
            t_exp_byte e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected word: out_byte %h run_last %b", b, last);
                errors++;
                return;
            end
            e = expected_bytes.pop_front();
            bytes_checked++;
            if (b !== e.value) begin
                $error("out_byte: expected %h, got %h", e.value, b);
                errors++;
            end
            if (last !== e.last) begin
                $error("run_last: expected %b, got %b", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    u16u8_in_if  in_ch();
    u16u8_out_if out_ch();

    utf16_to_utf8_encoder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_utf8_tracker tracker = new();

    int send_idle_pct;
    int recv_idle_pct;
    int units_sent;
    bit stall_req;
    int stall_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("utf16_to_utf8_encoder regression: fail");
        $finish;
    end

    // words are taken on the edge where valid and ready were both high
    always @(posedge clk) begin
        if (rst_n && in_ch.valid && in_ch.ready) begin
            tracker.note_unit(in_ch.code_unit, in_ch.end_of_text);
        end
        if (rst_n && out_ch.valid && out_ch.ready) begin
            tracker.check_byte(out_ch.out_byte, out_ch.run_last);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_req) begin
                stall_left = 300;
                stall_req  = 1'b0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_unit(input logic [15:0] unit, input logic eot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid       <= 1'b0;
            in_ch.code_unit   <= 16'($urandom);
            in_ch.end_of_text <= 1'($urandom);
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.code_unit   <= unit;
        in_ch.end_of_text <= eot;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        units_sent++;
    endtask

    function automatic t_unit_kind pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return K_ASCII;
        if (r < 35) return K_TWO;
        if (r < 55) return K_THREE;
        if (r < 75) return K_PAIR;
        if (r < 82) return K_LONE_HIGH;
        if (r < 88) return K_LONE_LOW;
        return K_ANY;
    endfunction

    task automatic send_random();
        t_unit_kind  kind;
        logic        eot;
        logic [15:0] unit;
        kind = pick_kind();
        eot  = ($urandom_range(0, 7) == 0);
        case (kind)
            K_ASCII: begin
                send_unit(16'($urandom_range(0, 16'h7F)), eot);
            end
            K_TWO: begin
                send_unit(16'($urandom_range(16'h80, 16'h7FF)), eot);
            end
            K_THREE: begin
                unit = 16'($urandom_range(16'h800, 16'hFFFF));
                // move surrogates out of the way
                if (unit[15:11] == 5'b11011) begin
                    unit[15:11] = 5'b11101;
                end
                send_unit(unit, eot);
            end
            K_PAIR: begin
                send_unit({HIGH_SURR_PREFIX, 10'($urandom)}, 1'b0);
                send_unit({LOW_SURR_PREFIX, 10'($urandom)}, eot);
            end
            K_LONE_HIGH: begin
                send_unit({HIGH_SURR_PREFIX, 10'($urandom)}, eot);
            end
            K_LONE_LOW: begin
                send_unit({LOW_SURR_PREFIX, 10'($urandom)}, eot);
            end
            default: begin
                send_unit(16'($urandom), eot);
            end
        endcase
    endtask

    task automatic run_random(input int n_units);
        int target;
        target = units_sent + n_units;
        while (units_sent < target) send_random();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        // let the monitor note the last accepted word first
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_unit(16'hE000, 1'b1);
        send_unit(16'hD7FF, 1'b0);
        // lone low surrogates
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDFFF, 1'b0);
        // smallest and largest supplementary code points
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // high surrogate as the final unit
        send_unit(16'hD800, 1'b1);
        // held high followed by a plain unit, then by another high
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDC00, 1'b0);
        // six bytes from one word
        send_unit(16'hD834, 1'b0);
        send_unit(16'h20AC, 1'b0);
        send_unit(16'hDB40, 1'b0);
        send_unit(16'hDBC0, 1'b1);
        send_unit(16'h0041, 1'b1);
    endtask

    initial begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.code_unit   <= '0;
        in_ch.end_of_text <= 1'b0;
        units_sent    = 0;
        stall_req     = 1'b0;
        stall_left    = 0;
        send_idle_pct = 6;
        recv_idle_pct = 63;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(32);

        // hold the output off while the sender keeps pushing, then let it drain
        send_idle_pct = 0;
        stall_req     = 1'b1;
        run_random(12);
        wait_drained();

        send_idle_pct = 63;
        recv_idle_pct = 6;
        run_random(32);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(32);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("covered %0d units: %0d bytes checked, %0d surrogate pairs, %0d replacement chars",
                 tracker.units, tracker.bytes_checked, tracker.pairs, tracker.replacements);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("utf16_to_utf8_encoder regression: pass");
        end else begin
            $display("utf16_to_utf8_encoder regression: fail");
        end
        $finish;
    end

endmodule
